FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/edf_pkg.sv
// ----------------------------------------------------------------------------
// edf_pkg
// Types and constants shared by the expiring duplicate filter and its cells.
// ----------------------------------------------------------------------------
package edf_pkg;

    localparam int ENTRIES  = 64;
    localparam int KEY_BITS = 64;
    localparam int TIME_W   = 32;
    localparam int LIFE_W   = 16;
    localparam int OCC_W    = 7;
    localparam int CNT_W    = $clog2(ENTRIES + 1);
    localparam int OCC_MAX  = 127;

    localparam logic [LIFE_W-1:0] LIFETIME_RESET = 16'd60;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_CLEAR  = 1'b1;

    localparam logic [1:0] STATUS_ACCEPTED  = 2'd0;
    localparam logic [1:0] STATUS_DUPLICATE = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;
    localparam logic [1:0] STATUS_CLEARED   = 2'd3;

    typedef struct packed {
        logic             mode;
        logic [63:0]      task_key;
        logic [TIME_W-1:0] now_seconds;
    } in_item_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [OCC_W-1:0] occupancy;
    } out_item_t;

    // Lookup token that walks the cell chain, one cell per cycle.
    typedef struct packed {
        logic                active;
        logic [KEY_BITS-1:0] key;
        logic [TIME_W-1:0]   now_seconds;
        logic                dup;
        logic                found;
        logic [CNT_W-1:0]    count;
    } token_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                clear;
        logic                write;
        logic [KEY_BITS-1:0] key;
        logic [TIME_W-1:0]   expiry;
    } commit_t;

endpackage

FILE: design/expiring_dedup_filter_unit.sv
// Insert: the lookup token walks the chain of ENTRIES slot cells one cell per cycle,
// each cell registering it, and the result is registered when it leaves the tail.
// One insert is in flight at a time; the next is taken only after the walk ends.
// Clear: result valid one cycle after acceptance, all slots emptied at once.
// Reset empties every slot and sets the lifetime to 60 seconds.
// ----------------------------------------------------------------------------
// expiring_dedup_filter_unit
// Duplicate filter with per-entry expiry, built as a chain of slot cells.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module expiring_dedup_filter_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  edf_pkg::in_item_t            in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output edf_pkg::out_item_t           out_data,
    input  logic                         cfg_wr_en,
    input  logic [edf_pkg::LIFE_W-1:0]   cfg_wr_data
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_WALK = 2'b10
    } state_t;

    state_t                         state_reg, state_next;
    logic [edf_pkg::LIFE_W-1:0]     lifetime_reg;
    logic [edf_pkg::KEY_BITS-1:0]   key_reg;
    logic [edf_pkg::TIME_W-1:0]     expiry_reg;
    logic                           out_valid_reg, out_valid_next;
    edf_pkg::out_item_t             out_data_reg, out_data_next;

    edf_pkg::token_t                tok [0:edf_pkg::ENTRIES];
    edf_pkg::token_t                tail;
    edf_pkg::commit_t               commit;

    logic                           accept;
    logic                           accept_insert;
    logic                           accept_clear;
    logic [edf_pkg::TIME_W:0]       expiry_sum;
    logic [edf_pkg::TIME_W-1:0]     expiry_sat;
    logic                           tail_accept;
    logic [edf_pkg::CNT_W-1:0]      final_count;
    logic [1:0]                     final_status;
    logic [edf_pkg::OCC_W-1:0]      final_occ;

    assign in_ready      = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept        = in_valid && in_ready;
    assign accept_insert = accept && (in_data.mode == edf_pkg::MODE_INSERT);
    assign accept_clear  = accept && (in_data.mode == edf_pkg::MODE_CLEAR);

    assign expiry_sum = {1'b0, in_data.now_seconds}
                      + (edf_pkg::TIME_W + 1)'(lifetime_reg);
    assign expiry_sat = expiry_sum[edf_pkg::TIME_W] ? '1
                      : expiry_sum[edf_pkg::TIME_W-1:0];

    // Head of the chain: a fresh token for an accepted insert.
    always_comb
    begin
        tok[0]             = '0;
        tok[0].active      = accept_insert;
        tok[0].key         = in_data.task_key[edf_pkg::KEY_BITS-1:0];
        tok[0].now_seconds = in_data.now_seconds;
    end

    genvar gi;
    generate
        for (gi = 0; gi < edf_pkg::ENTRIES; gi++)
        begin : g_cell
            edf_cell u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .tok_in (tok[gi]),
                .tok_out(tok[gi+1]),
                .commit (commit)
            );
        end
    endgenerate

    assign tail        = tok[edf_pkg::ENTRIES];
    assign tail_accept = tail.active && !tail.dup && tail.found;
    assign final_count = tail.count + edf_pkg::CNT_W'(tail_accept);

    always_comb
    begin
        if (tail.dup)
        begin
            final_status = edf_pkg::STATUS_DUPLICATE;
        end
        else if (!tail.found)
        begin
            final_status = edf_pkg::STATUS_FULL;
        end
        else
        begin
            final_status = edf_pkg::STATUS_ACCEPTED;
        end
        if (32'(final_count) > 32'(edf_pkg::OCC_MAX))
        begin
            final_occ = edf_pkg::OCC_W'(edf_pkg::OCC_MAX);
        end
        else
        begin
            final_occ = edf_pkg::OCC_W'(final_count);
        end
    end

    always_comb
    begin
        commit.clear  = accept_clear;
        commit.write  = tail_accept;
        commit.key    = key_reg;
        commit.expiry = expiry_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept_insert)
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (tail.active)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (accept_clear)
        begin
            out_valid_next          = 1'b1;
            out_data_next.status    = edf_pkg::STATUS_CLEARED;
            out_data_next.occupancy = '0;
        end
        else if (tail.active)
        begin
            out_valid_next          = 1'b1;
            out_data_next.status    = final_status;
            out_data_next.occupancy = final_occ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lifetime_reg  <= edf_pkg::LIFETIME_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                lifetime_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (accept_insert)
        begin
            key_reg    <= in_data.task_key[edf_pkg::KEY_BITS-1:0];
            expiry_reg <= expiry_sat;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `ASSERT_SAME(a_tail_in_walk, tail.active, state_reg == ST_WALK,
        "Lookup token left the chain outside a walk.")
    `ASSERT_NEXT(a_insert_starts_walk, accept_insert, state_reg == ST_WALK,
        "Accepted insert did not start a walk.")
    `ASSERT_ALWAYS(a_no_clear_during_commit, !(commit.clear && commit.write),
        "Clear and slot write in the same cycle.")
    `ASSERT_NEXT(a_accept_occupied, tail_accept, out_data_reg.occupancy != '0,
        "Accepted transaction reported an empty table.")

endmodule

FILE: design/edf_cell.sv
// ----------------------------------------------------------------------------
// edf_cell
// One table slot: drops itself when expired, checks the passing token for a
// key match, claims itself as the first free slot and forwards the token.
// ----------------------------------------------------------------------------
module edf_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  edf_pkg::token_t   tok_in,
    output edf_pkg::token_t   tok_out,
    input  edf_pkg::commit_t  commit
);

    logic                         valid_reg, valid_next;
    logic                         cand_reg, cand_next;
    logic [edf_pkg::KEY_BITS-1:0] key_reg;
    logic [edf_pkg::TIME_W-1:0]   expiry_reg;
    edf_pkg::token_t              tok_reg, tok_next;
    logic                         valid_eff;
    logic                         take;

    assign valid_eff = valid_reg && !(expiry_reg < tok_in.now_seconds);
    assign take      = tok_in.active && !valid_eff && !tok_in.found;

    always_comb
    begin
        tok_next       = tok_in;
        tok_next.dup   = tok_in.dup || (valid_eff && (key_reg == tok_in.key));
        tok_next.found = tok_in.found || !valid_eff;
        tok_next.count = tok_in.count + edf_pkg::CNT_W'(valid_eff);
        if (!tok_in.active)
        begin
            tok_next.active = 1'b0;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (commit.clear)
        begin
            valid_next = 1'b0;
        end
        else if (commit.write && cand_reg)
        begin
            valid_next = 1'b1;
        end
        else if (tok_in.active)
        begin
            valid_next = valid_eff;
        end
    end

    // The claim is refreshed by every passing token, so only the lowest
    // free slot of the latest lookup holds it at commit time.
    assign cand_next = tok_in.active ? take : cand_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            cand_reg  <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            cand_reg  <= cand_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit.write && cand_reg)
        begin
            key_reg    <= commit.key;
            expiry_reg <= commit.expiry;
        end
    end

    assign tok_out = tok_reg;

endmodule
